### src/tpsp_pkg.sv
// ----------------------------------------------------------------------------
// tpsp_pkg
// Shared types and constants of the three-phase sine PWM generator.
// ----------------------------------------------------------------------------
package tpsp_pkg;

	localparam int TABLE_LEN_DEF = 1800;
	localparam int SUB_STEPS     = 10000;

	localparam int IDX_W    = 11;
	localparam int SAMPLE_W = 16;
	localparam int CMP_W    = 9;
	localparam int STEP_W   = 22;
	localparam int GAIN_W   = 17;
	localparam int OFF_W    = 32;

	// V/f gain: g = clamp(floor(|step| * 2048 / 3375), 6554, 65536)
	localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
	localparam logic [GAIN_W-1:0] GAIN_MIN   = 17'd6554;
	localparam logic [STEP_W-1:0] MAG_SAT    = 22'd108000;
	localparam logic [20:0]       GAIN_RECIP = 21'd1272582;
	localparam logic [11:0]       GAIN_DIV   = 12'd3375;

	// (GAIN_ONE - 0) * 32767, the blend offset while the gain is zero
	localparam logic [OFF_W-1:0] OFF_RST = 32'h7FFF_0000;

	localparam logic [CMP_W-1:0]    CMP_SPAN = 9'd493;
	localparam logic [CMP_W-1:0]    CMP_BASE = 9'd4;
	localparam logic [SAMPLE_W-1:0] CMP_FULL = 16'hFFFF;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic [1:0] LANE_A = 2'd0;
	localparam logic [1:0] LANE_B = 2'd1;
	localparam logic [1:0] LANE_C = 2'd2;

	typedef struct packed {
		logic                action;
		logic [IDX_W-1:0]    table_index;
		logic [SAMPLE_W-1:0] table_value;
	} tpsp_req_t;

	typedef struct packed {
		logic [CMP_W-1:0] compare_a;
		logic [CMP_W-1:0] compare_b;
		logic [CMP_W-1:0] compare_c;
	} tpsp_res_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] lane;
	} tpsp_tok_t;

	typedef struct packed {
		logic              busy;
		logic [GAIN_W-1:0] gain;
		logic [OFF_W-1:0]  offset;
	} tpsp_cfg_t;

endpackage

### src/tpsp_gain.sv
// ----------------------------------------------------------------------------
// tpsp_gain
// Phase step register: reduces the step modulo the accumulator range and
// derives the V/f amplitude gain and its blend offset in the MUL, FIX and OFF states.
// ----------------------------------------------------------------------------
module tpsp_gain
	import tpsp_pkg::*;
#(
	parameter int TABLE_LEN = TABLE_LEN_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [STEP_W-1:0]                       cfg_wdata,
	output tpsp_cfg_t                               cfg,
	output logic [$clog2(TABLE_LEN*SUB_STEPS)-1:0] step_red
);

	localparam int AW      = $clog2(TABLE_LEN * SUB_STEPS);
	localparam int RW      = ((AW > STEP_W) ? AW : STEP_W) + 1;
	localparam int ACC_MOD = TABLE_LEN * SUB_STEPS;

	localparam logic [1:0] GS_IDLE = 2'd0;
	localparam logic [1:0] GS_MUL  = 2'd1;
	localparam logic [1:0] GS_FIX  = 2'd2;
	localparam logic [1:0] GS_OFF  = 2'd3;

	localparam logic signed [RW-1:0] MOD_S = RW'(ACC_MOD);

	logic [1:0]              gstate_q;
	logic signed [RW-1:0]    step_q;
	logic                    red_busy_q;
	logic [STEP_W-1:0]       mag_q;
	logic                    sat_q;
	logic [37:0]             prod_q;
	logic [GAIN_W-1:0]       gain_q;
	logic [OFF_W-1:0]        off_q;

	logic [STEP_W-1:0]       mag;
	logic [37:0]             mul;
	logic [GAIN_W-1:0]       qe;
	logic [28:0]             qe_x;
	logic [29:0]             rem;
	logic [GAIN_W-1:0]       q;
	logic [GAIN_W-1:0]       g;
	logic [GAIN_W-1:0]       inv;

	assign mag  = cfg_wdata[STEP_W-1] ? (~cfg_wdata + 1'b1) : cfg_wdata;
	assign mul  = mag_q[16:0] * GAIN_RECIP;
	assign qe   = prod_q[37:21];
	assign qe_x = qe * GAIN_DIV;
	assign rem  = {2'b00, mag_q[16:0], 11'd0} - {1'b0, qe_x};
	assign q    = (rem >= {18'd0, GAIN_DIV}) ? (qe + 1'b1) : qe;
	assign g    = sat_q ? GAIN_ONE : ((q < GAIN_MIN) ? GAIN_MIN : q);
	assign inv  = GAIN_ONE - gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gstate_q   <= GS_IDLE;
			step_q     <= '0;
			red_busy_q <= 1'b0;
			gain_q     <= '0;
			off_q      <= OFF_RST;
		end else if (cfg_we) begin
			gstate_q   <= GS_MUL;
			step_q     <= {{(RW-STEP_W){cfg_wdata[STEP_W-1]}}, cfg_wdata};
			red_busy_q <= 1'b1;
		end else begin
			if (red_busy_q) begin
				if (step_q[RW-1]) begin
					step_q <= step_q + MOD_S;
				end else if (step_q >= MOD_S) begin
					step_q <= step_q - MOD_S;
				end else begin
					red_busy_q <= 1'b0;
				end
			end
			case (gstate_q)
				GS_MUL: begin
					gstate_q <= GS_FIX;
				end
				GS_FIX: begin
					gain_q   <= g;
					gstate_q <= GS_OFF;
				end
				GS_OFF: begin
					off_q    <= {inv[16:0], 15'd0} - {15'd0, inv};
					gstate_q <= GS_IDLE;
				end
				default: begin
					gstate_q <= GS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_we) begin
			mag_q <= mag;
			sat_q <= (mag >= MAG_SAT);
		end
		if (gstate_q == GS_MUL) begin
			prod_q <= mul;
		end
	end

	assign cfg.busy   = (gstate_q != GS_IDLE) || red_busy_q;
	assign cfg.gain   = gain_q;
	assign cfg.offset = off_q;
	assign step_red   = step_q[AW-1:0];

endmodule

### src/tpsp_table.sv
// ----------------------------------------------------------------------------
// tpsp_table
// Sine table: single-port write, registered read, no reset contents.
// ----------------------------------------------------------------------------
module tpsp_table
	import tpsp_pkg::*;
#(
	parameter int TABLE_LEN = TABLE_LEN_DEF
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(TABLE_LEN)-1:0] waddr,
	input  logic [SAMPLE_W-1:0]          wdata,
	input  logic                         re,
	input  logic [$clog2(TABLE_LEN)-1:0] raddr,
	output logic [SAMPLE_W-1:0]          rdata
);

	logic [SAMPLE_W-1:0] mem [TABLE_LEN];
	logic [SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/tpsp_scale.sv
// ----------------------------------------------------------------------------
// tpsp_scale
// Sample pipeline: gain blend toward mid-scale, then map onto 4..497.
// One sample per cycle, tagged with its phase lane.
// ----------------------------------------------------------------------------
module tpsp_scale
	import tpsp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  tpsp_tok_t           tok,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [GAIN_W-1:0]   gain,
	input  logic [OFF_W-1:0]    offset,
	output tpsp_tok_t           tok_out,
	output logic [CMP_W-1:0]    cmp
);

	tpsp_tok_t         tok_s1;
	tpsp_tok_t         tok_s2;
	tpsp_tok_t         tok_s3;
	tpsp_tok_t         tok_s4;
	logic [15:0]       x_s2;
	logic [24:0]       y_s3;
	logic [CMP_W-1:0]  cmp_s4;

	logic [32:0]       gs;
	logic [33:0]       sum;
	logic [24:0]       y;
	logic [CMP_W-1:0]  yq;
	logic [16:0]       ylo;
	logic [CMP_W-1:0]  q;

	assign gs  = gain * sample;
	assign sum = {1'b0, gs} + {2'b00, offset};
	assign y   = x_s2 * CMP_SPAN;
	assign yq  = y_s3[24:16];
	assign ylo = {1'b0, y_s3[15:0]} + {8'd0, yq};
	assign q   = yq + {8'd0, (ylo >= {1'b0, CMP_FULL})};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			tok_s3 <= '0;
			tok_s4 <= '0;
		end else begin
			tok_s1 <= tok;
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
			tok_s4 <= tok_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s2   <= sum[31:16];
		y_s3   <= y;
		cmp_s4 <= q + CMP_BASE;
	end

	assign tok_out = tok_s4;
	assign cmp     = cmp_s4;

endmodule

### src/three_phase_sine_pwm_generator_core.sv
// ----------------------------------------------------------------------------
// three_phase_sine_pwm_generator_core
// Three-phase sine PWM generator. A tick request advances the phase
// accumulator by the reduced phase step and returns three compare values
// 4..497 for the base table index and the indexes one third and two thirds
// of a period on. A table-write request loads one sine entry and returns
// nothing; entries must be written before a tick reads them. A tick passes
// through the accumulator update, a reciprocal divide by 10000 (DIV1, DIV2,
// IDX), three reads through the single table port, the four-stage scaling
// pipeline (its first stage is the table read) and the result handoff
// (DRAIN, DONE), which waits while an earlier result is still unaccepted;
// the next request is taken back in idle. A new tick is taken while the
// previous result still waits on res_ready. A cfg_we write holds off
// requests for the gain pipeline and the step reduction, which adds or
// subtracts TABLE_LEN*10000 until the step lies in range. Compare values
// returned by ticks sit at mid-scale until the first cfg_we write.
// ----------------------------------------------------------------------------
module three_phase_sine_pwm_generator_core
	import tpsp_pkg::*;
#(
	parameter int TABLE_LEN = TABLE_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [STEP_W-1:0] cfg_wdata,
	input  logic              req_valid,
	output logic              req_ready,
	input  tpsp_req_t         req_data,
	output logic              res_valid,
	input  logic              res_ready,
	output tpsp_res_t         res_data
);

	localparam int AW      = $clog2(TABLE_LEN * SUB_STEPS);
	localparam int IW      = $clog2(TABLE_LEN);
	localparam int ACC_MOD = TABLE_LEN * SUB_STEPS;
	localparam longint unsigned DIV_K = (64'd1 << AW) / SUB_STEPS;
	localparam int KW      = $clog2(DIV_K + 1);
	localparam int OFF_B   = (2 * TABLE_LEN) / 3;
	localparam int OFF_C   = TABLE_LEN / 3;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV1  = 3'd1;
	localparam logic [2:0] ST_DIV2  = 3'd2;
	localparam logic [2:0] ST_IDX   = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	tpsp_cfg_t          cfg;
	logic [AW-1:0]      step_red;

	logic [2:0]         state_q;
	logic [AW-1:0]      acc_q;
	logic [AW+KW-1:0]   prod_q;
	logic [IW-1:0]      qe_q;
	logic [14:0]        rem_q;
	logic [IW-1:0]      ia_q;
	logic [1:0]         lane_q;
	logic [CMP_W-1:0]   pend_a_q;
	logic [CMP_W-1:0]   pend_b_q;
	logic [CMP_W-1:0]   pend_c_q;
	logic               res_valid_q;
	tpsp_res_t          res_q;

	logic               accept;
	logic               tick;
	logic               tbl_we;
	logic [IW+IDX_W-1:0] widx_ext;
	logic [AW:0]        acc_sum;
	logic [AW-1:0]      acc_nxt;
	logic [AW+KW-1:0]   div_prod;
	logic [KW-1:0]      div_qe;
	logic [AW:0]        rem_full;
	logic [IW:0]        ib_sum;
	logic [IW:0]        ic_sum;
	logic [IW-1:0]      ib;
	logic [IW-1:0]      ic;
	logic [IW-1:0]      raddr;
	logic [SAMPLE_W-1:0] rdata;
	tpsp_tok_t          rd_tok;
	tpsp_tok_t          sc_tok;
	logic [CMP_W-1:0]   sc_cmp;
	logic               load_res;

	tpsp_gain #(
		.TABLE_LEN (TABLE_LEN)
	) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.step_red  (step_red)
	);

	assign req_ready = (state_q == ST_IDLE) && !cfg.busy;
	assign accept    = req_valid && req_ready;
	assign tick      = accept && (req_data.action == ACT_TICK);
	assign widx_ext  = {{IW{1'b0}}, req_data.table_index};
	assign tbl_we    = accept && (req_data.action == ACT_WRITE) &&
		(widx_ext < (IW+IDX_W)'(TABLE_LEN));

	assign acc_sum = {1'b0, acc_q} + {1'b0, step_red};
	assign acc_nxt = (acc_sum >= (AW+1)'(ACC_MOD)) ?
		AW'(acc_sum - (AW+1)'(ACC_MOD)) : acc_sum[AW-1:0];

	assign div_prod = acc_q * KW'(DIV_K);
	assign div_qe   = prod_q[AW+KW-1:AW];
	assign rem_full = {1'b0, acc_q} - (AW+1)'(div_qe * SUB_STEPS);

	assign ib_sum = {1'b0, ia_q} + (IW+1)'(OFF_B);
	assign ic_sum = {1'b0, ia_q} + (IW+1)'(OFF_C);
	assign ib = (ib_sum >= (IW+1)'(TABLE_LEN)) ?
		IW'(ib_sum - (IW+1)'(TABLE_LEN)) : ib_sum[IW-1:0];
	assign ic = (ic_sum >= (IW+1)'(TABLE_LEN)) ?
		IW'(ic_sum - (IW+1)'(TABLE_LEN)) : ic_sum[IW-1:0];

	always_comb begin
		case (lane_q)
			LANE_A:  raddr = ia_q;
			LANE_B:  raddr = ib;
			LANE_C:  raddr = ic;
			default: raddr = ia_q;
		endcase
	end

	assign rd_tok.valid = (state_q == ST_READ);
	assign rd_tok.lane  = lane_q;

	tpsp_table #(
		.TABLE_LEN (TABLE_LEN)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (widx_ext[IW-1:0]),
		.wdata (req_data.table_value),
		.re    (rd_tok.valid),
		.raddr (raddr),
		.rdata (rdata)
	);

	tpsp_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok     (rd_tok),
		.sample  (rdata),
		.gain    (cfg.gain),
		.offset  (cfg.offset),
		.tok_out (sc_tok),
		.cmp     (sc_cmp)
	);

	assign load_res = (state_q == ST_DONE) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			lane_q      <= LANE_A;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick) begin
						acc_q   <= acc_nxt;
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					state_q <= ST_IDX;
				end
				ST_IDX: begin
					lane_q  <= LANE_A;
					state_q <= ST_READ;
				end
				ST_READ: begin
					case (lane_q)
						LANE_A:  lane_q <= LANE_B;
						LANE_B:  lane_q <= LANE_C;
						default: begin
							lane_q  <= LANE_A;
							state_q <= ST_DRAIN;
						end
					endcase
				end
				ST_DRAIN: begin
					if (sc_tok.valid && (sc_tok.lane == LANE_C)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV1) begin
			prod_q <= div_prod;
		end
		if (state_q == ST_DIV2) begin
			qe_q  <= IW'(div_qe);
			rem_q <= rem_full[14:0];
		end
		if (state_q == ST_IDX) begin
			ia_q <= qe_q + {{(IW-1){1'b0}}, (rem_q >= 15'(SUB_STEPS))};
		end
		if (sc_tok.valid) begin
			case (sc_tok.lane)
				LANE_A:  pend_a_q <= sc_cmp;
				LANE_B:  pend_b_q <= sc_cmp;
				default: pend_c_q <= sc_cmp;
			endcase
		end
		if (load_res) begin
			res_q.compare_a <= pend_a_q;
			res_q.compare_b <= pend_b_q;
			res_q.compare_c <= pend_c_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

### src/tpsp_checker.sv
// ----------------------------------------------------------------------------
// tpsp_checker
// Port-level checks of the three-phase sine PWM generator, bound to the top.
// ----------------------------------------------------------------------------
module tpsp_checker
	import tpsp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      cfg_we,
	input logic      req_valid,
	input logic      req_ready,
	input tpsp_req_t req_data,
	input logic      res_valid,
	input logic      res_ready,
	input tpsp_res_t res_data
);

	// result held until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped or changed while stalled");

	// a tick request keeps the block busy on the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_data.action == ACT_TICK) |=> !req_ready)
		else $error("request taken during tick processing");

	// gain update blocks requests right after a write
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !req_ready)
		else $error("request taken during gain update");

	// compare values stay in the PWM range
	a_cmp_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
			res_data.compare_a >= CMP_BASE && res_data.compare_a <= 9'd497 &&
			res_data.compare_b >= CMP_BASE && res_data.compare_b <= 9'd497 &&
			res_data.compare_c >= CMP_BASE && res_data.compare_c <= 9'd497)
		else $error("compare value out of range");

endmodule

bind three_phase_sine_pwm_generator_core tpsp_checker u_tpsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req_data  (req_data),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_data  (res_data)
);
